// ===== sv/kmq_pkg.sv =====
// Package for the key matrix change event queue.
// Holds sizes, field widths, operation codes and the controller state type.
// No dependencies.
`default_nettype none

package kmq_pkg;

  // Matrix and queue sizes
  localparam int ROWS        = 9;
  localparam int QUEUE_DEPTH = 16;

  // Field widths
  localparam int ROW_W  = 4;
  localparam int BITS_W = 8;
  localparam int COL_W  = 3;
  localparam int KEY_W  = ROW_W + COL_W;

  // Derived storage widths
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = $clog2(QUEUE_DEPTH);
  localparam int EV_W   = KEY_W + 1;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);
  localparam logic [ROW_W:0]    ROW_LIMIT = (ROW_W + 1)'(ROWS);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(BITS_W - 1);

  // Operation codes
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POP
  } kmq_state_t;

endpackage

`default_nettype wire

// ===== sv/key_matrix_change_event_queue_core.sv =====
// Read path: an accepted read word enters the pop state, which loads the result into the
// output registers once any earlier result has been taken (held while out_ready is low).
// A scan word reads the previous row from memory at acceptance, then walks one column per
// cycle over 8 columns, each queueing at most one event into the event RAM.
// A new word is accepted only in the idle state, once the previous scan or read is done.
// Reset (rst, synchronous): queue empty, all previous rows read as zero, no result pending.
// Depends on kmq_pkg.
`default_nettype none

module key_matrix_change_event_queue_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        operation,
  input  logic [kmq_pkg::ROW_W-1:0]   row_index,
  input  logic [kmq_pkg::BITS_W-1:0]  row_bits,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kmq_pkg::KEY_W-1:0]   event_key,
  output logic                        event_pressed,
  output logic                        queue_empty
);
  import kmq_pkg::*;

  kmq_state_t state, state_next;

  // Memories
  logic [BITS_W-1:0] prev_mem [ROWS];
  logic [EV_W-1:0]   ev_mem   [QUEUE_DEPTH];
  logic [ROWS-1:0]   row_vld;

  logic [BITS_W-1:0] prev_rd;
  logic              prev_vld_q;
  logic [EV_W-1:0]   ev_rd;

  // Word capture
  logic [ROW_W-1:0]  row_q;
  logic [BITS_W-1:0] bits_q;
  logic              empty_q;
  logic [COL_W-1:0]  bit_cnt;

  // Queue pointers
  logic [SLOT_W-1:0] read_slot;
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] write_slot_next;
  logic [SLOT_W-1:0] read_slot_next;

  // Control
  logic              accept;
  logic              row_ok;
  logic [ROW_AW-1:0] row_addr;
  logic [BITS_W-1:0] diff;
  logic              push_en;
  logic              load_out;
  logic [EV_W-1:0]   push_word;

  assign accept   = in_valid && in_ready;
  assign row_ok   = ({1'b0, row_index} < ROW_LIMIT);
  assign row_addr = row_index[ROW_AW-1:0];
  assign diff     = (prev_vld_q ? prev_rd : '0) ^ bits_q;

  assign write_slot_next = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  assign read_slot_next  = (read_slot == LAST_SLOT) ? '0 : read_slot + 1'b1;
  assign push_word       = {bits_q[bit_cnt], row_q, bit_cnt};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (operation == OP_READ) begin
            state_next = ST_POP;
          end else if (row_ok) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (bit_cnt == LAST_COL) begin
          state_next = ST_IDLE;
        end
      end
      ST_POP: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = 1'b0;
    push_en  = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: push_en  = diff[bit_cnt] && (write_slot_next != read_slot);
      ST_POP:  load_out = !out_valid || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  // Previous-row memory: read-first, written with the new row at acceptance
  always_ff @(posedge clk) begin
    if (accept && operation == OP_SCAN && row_ok) begin
      prev_rd <= prev_mem[row_addr];
      prev_mem[row_addr] <= row_bits;
    end
  end

  // Event RAM
  always_ff @(posedge clk) begin
    if (push_en) begin
      ev_mem[write_slot] <= push_word;
    end
    if (accept && operation == OP_READ) begin
      ev_rd <= ev_mem[read_slot];
    end
  end

  // Word payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      row_q   <= row_index;
      bits_q  <= row_bits;
      empty_q <= (read_slot == write_slot);
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      event_key     <= empty_q ? '0 : ev_rd[KEY_W-1:0];
      event_pressed <= empty_q ? 1'b0 : ev_rd[EV_W-1];
      queue_empty   <= empty_q;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      row_vld    <= '0;
      prev_vld_q <= 1'b0;
      bit_cnt    <= '0;
      read_slot  <= '0;
      write_slot <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && operation == OP_SCAN && row_ok) begin
        prev_vld_q        <= row_vld[row_addr];
        row_vld[row_addr] <= 1'b1;
      end
      if (state == ST_SCAN) begin
        bit_cnt <= bit_cnt + 1'b1;
      end
      if (push_en) begin
        write_slot <= write_slot_next;
      end
      if (load_out && !empty_q) begin
        read_slot <= read_slot_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("in_ready high while a word is in progress");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && queue_empty) |-> (event_key == '0 && !event_pressed))
    else $error("empty result carries nonzero event fields");

  a_push_in_scan: assert property (@(posedge clk) disable iff (rst)
    push_en |-> (state == ST_SCAN && write_slot_next != read_slot))
    else $error("event pushed outside column walk or into a full queue");

  a_read_slot_scan: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> (read_slot == $past(read_slot)))
    else $error("read slot moved during column walk");

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (bit_cnt == '0))
    else $error("column counter not at zero when idle");

endmodule

`default_nettype wire

// ===== sim/kmq_event_checker.sv =====
// Checker for the key matrix change event queue: watches both channels,
// keeps its own copy of row history and event queue, and compares each popped word.
// Depends on kmq_pkg.

module kmq_event_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        operation,
  input  logic [kmq_pkg::ROW_W-1:0]   row_index,
  input  logic [kmq_pkg::BITS_W-1:0]  row_bits,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [kmq_pkg::KEY_W-1:0]   event_key,
  input  logic                        event_pressed,
  input  logic                        queue_empty,
  output int                          mismatches,
  output int                          waiting
);
  import kmq_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             pressed;
    logic             empty;
  } pop_word_t;

  // Last level seen per row, queued change events (bit 7 = pressed), pops still due
  logic [BITS_W-1:0] row_history [ROWS];
  logic [EV_W-1:0]   key_changes [$];
  pop_word_t         pops_due [$];
  int                fail_total;

  // Full queue drops the new change
  task automatic queue_change(input logic [EV_W-1:0] change);
    if (key_changes.size() < QUEUE_DEPTH - 1)
      key_changes.push_back(change);
  endtask

  // Diff a scanned row against history, lowest column first, release before press
  task automatic scan_row(input logic [ROW_W-1:0] r, input logic [BITS_W-1:0] levels);
    logic [BITS_W-1:0] went_up;
    logic [BITS_W-1:0] went_down;
    logic [KEY_W-1:0]  key;
    if (r < ROWS) begin
      went_down     = row_history[r] & ~levels;
      went_up       = levels & ~row_history[r];
      row_history[r] = levels;
      for (int c = 0; c < BITS_W; c++) begin
        key = {r, COL_W'(c)};
        if (went_down[c]) queue_change({1'b0, key});
        if (went_up[c])   queue_change({1'b1, key});
      end
    end
  endtask

  // A read word pops the oldest change or reports empty
  task automatic pop_change();
    pop_word_t res;
    res = '0;
    if (key_changes.size() == 0) begin
      res.empty = 1'b1;
    end else begin
      res.key     = key_changes[0][KEY_W-1:0];
      res.pressed = key_changes[0][EV_W-1];
      void'(key_changes.pop_front());
    end
    pops_due.push_back(res);
  endtask

  task automatic check_pop();
    pop_word_t want;
    if (pops_due.size() == 0) begin
      fail_total++;
      if (fail_total <= 10)
        $display("%0t: unexpected word: key %0d pressed %0b empty %0b",
                 $realtime, event_key, event_pressed, queue_empty);
    end else begin
      want = pops_due.pop_front();
      if (want.key !== event_key || want.pressed !== event_pressed ||
          want.empty !== queue_empty) begin
        fail_total++;
        if (fail_total <= 10)
          $display("%0t: mismatch: key %0d/%0d pressed %0b/%0b empty %0b/%0b (exp/act)",
                   $realtime, want.key, event_key, want.pressed, event_pressed,
                   want.empty, queue_empty);
      end
    end
  endtask

  // Predict on accepted input words, then compare accepted output words
  always @(posedge clk) begin
    if (rst) begin
      foreach (row_history[i]) row_history[i] = '0;
      key_changes.delete();
      pops_due.delete();
      fail_total = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (operation == OP_READ) pop_change();
        else scan_row(row_index, row_bits);
      end
      if (out_valid && out_ready) check_pop();
    end
    mismatches <= fail_total;
    waiting    <= pops_due.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for key_matrix_change_event_queue_core: clock, reset, scan/read
// stimulus, receiver stalls, watchdog and verdict. Depends on kmq_pkg and kmq_event_checker.

module tb_top;
  import kmq_pkg::*;

  localparam int RANDOM_WORDS = 1330;
  localparam int HOLD_START   = 2500;
  localparam int HOLD_CYCLES  = 600;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              operation;
  logic [ROW_W-1:0]  row_index;
  logic [BITS_W-1:0] row_bits;
  logic              out_valid;
  logic              out_ready;
  logic [KEY_W-1:0]  event_key;
  logic              event_pressed;
  logic              queue_empty;

  int mismatches;
  int waiting;
  int burst_left;
  int idle_cycles;
  int rx_cycles;
  int rx_mode;

  // Last levels sent per row index, used to make small level changes
  logic [BITS_W-1:0] sent_rows [16];

  key_matrix_change_event_queue_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .row_index     (row_index),
    .row_bits      (row_bits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_key     (event_key),
    .event_pressed (event_pressed),
    .queue_empty   (queue_empty)
  );

  kmq_event_checker chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .row_index     (row_index),
    .row_bits      (row_bits),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_key     (event_key),
    .event_pressed (event_pressed),
    .queue_empty   (queue_empty),
    .mismatches    (mismatches),
    .waiting       (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one word at the falling edge, hold until accepted; bursts end in a gap
  task automatic send_word(input logic op, input logic [ROW_W-1:0] r,
                           input logic [BITS_W-1:0] levels);
    in_valid  = 1'b1;
    operation = op;
    row_index = r;
    row_bits  = levels;
    if (op == OP_SCAN) sent_rows[r] = levels;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Stimulus and verdict
  initial begin
    int useful;
    int read_pct;
    int phase_words;
    int pick;
    logic [ROW_W-1:0]  r;
    logic [BITS_W-1:0] levels;

    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = OP_SCAN;
    row_index  = '0;
    row_bits   = '0;
    burst_left = 0;
    foreach (sent_rows[i]) sent_rows[i] = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: read on empty queue, all presses, top row, ignored rows,
    // releases that overflow the queue, then drain past empty
    send_word(OP_READ, 4'd0, 8'h00);
    send_word(OP_SCAN, 4'd0, 8'hFF);
    send_word(OP_SCAN, 4'(ROWS - 1), 8'hA5);
    send_word(OP_SCAN, 4'd15, 8'hFF);
    send_word(OP_SCAN, 4'(ROWS), 8'h3C);
    send_word(OP_SCAN, 4'd0, 8'h0F);
    send_word(OP_READ, 4'd15, 8'hFF);
    repeat (QUEUE_DEPTH - 1) send_word(OP_READ, 4'd0, 8'h00);

    // Random: phases of varying read share so the queue fills and drains
    useful      = 0;
    read_pct    = 45;
    phase_words = 0;
    while (useful < RANDOM_WORDS) begin
      if (phase_words == 0) begin
        case ($urandom_range(0, 2))
          0:       read_pct = 10;
          1:       read_pct = 45;
          default: read_pct = 85;
        endcase
        phase_words = $urandom_range(30, 90);
      end
      phase_words--;
      if ($urandom_range(0, 99) < read_pct) begin
        send_word(OP_READ, 4'($urandom), 8'($urandom));
        useful++;
      end else begin
        r = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(ROWS, 15))
                                         : 4'($urandom_range(0, ROWS - 1));
        pick = $urandom_range(0, 9);
        case (pick)
          0:       levels = 8'h00;
          1:       levels = 8'hFF;
          2, 3, 4, 5: levels = sent_rows[r] ^ (8'h01 << $urandom_range(0, 7));
          6, 7:    levels = sent_rows[r] ^ 8'($urandom);
          default: levels = 8'($urandom);
        endcase
        send_word(OP_SCAN, r, levels);
        if (r < ROWS) useful++;
      end
    end
    in_valid = 1'b0;

    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && waiting == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: randomly chosen stall modes, plus one long hold-off
  initial begin
    out_ready = 1'b1;
    rx_cycles = 0;
    rx_mode   = 0;
    forever begin
      @(negedge clk);
      if (!rst) rx_cycles++;
      if (rx_cycles == HOLD_START) begin
        // hold off long enough for the block to back up its input
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_cycles++;
      end else begin
        if (rx_cycles % 64 == 0) rx_mode = $urandom_range(0, 2);
        case (rx_mode)
          0:       out_ready = 1'b1;
          1:       out_ready = 1'($urandom_range(0, 1));
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog: too many cycles with no word moving on either channel
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
